FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the RTL of the bordered square finder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/lobs_pkg.sv
// ----------------------------------------------------------------------------
// Bordered square finder package
// Types and constants shared by the cell chain and the top level.
// ----------------------------------------------------------------------------
package lobs_pkg;

   localparam int ROW_W   = 64;
   localparam int DIM_W   = 7;
   localparam int CELLS_W = 13;

   localparam logic CSR_GRID_ROWS = 1'b0;
   localparam logic CSR_GRID_COLS = 1'b1;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SEARCH,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic step;
   } cell_ctrl_type;

   typedef struct packed {
      logic [ROW_W-1:0] bot;
      logic [ROW_W-1:0] vert;
      logic [ROW_W-1:0] rgt;
   } link_type;

endpackage

FILE: hw/rtl/lobs_cell.sv
// ----------------------------------------------------------------------------
// Grid row cell
// Holds one grid row and its horizontal, vertical, bottom and right-edge spans
// for the current side, stepping them one side length per cycle in a search.
// ----------------------------------------------------------------------------
module lobs_cell (
   input  logic                        clock,
   input  lobs_pkg::cell_ctrl_type     ctrl,
   input  logic [lobs_pkg::ROW_W-1:0]  row_bits,
   input  lobs_pkg::link_type          link_in,
   output lobs_pkg::link_type          link_out,
   output logic                        hit
);
   import lobs_pkg::*;

   logic [ROW_W-1:0] w_ff;
   logic [ROW_W-1:0] b_ff;
   logic [ROW_W-1:0] v_ff;
   logic [ROW_W-1:0] r_ff;
   logic             hit_ff;
   logic [ROW_W-1:0] rv_in;

   // Right-edge span of this row combined with that of the row below; shifted by
   // one column it becomes the right-edge span for the next square side.
   assign rv_in = r_ff & link_in.rgt;

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         w_ff <= '0;
         b_ff <= '0;
         v_ff <= '0;
         r_ff <= '0;
      end else if (ctrl.load) begin
         w_ff <= row_bits;
         b_ff <= row_bits;
         v_ff <= row_bits;
         r_ff <= row_bits;
      end else if (ctrl.step) begin
         w_ff   <= w_ff & (w_ff >> 1);
         b_ff   <= link_in.bot & (link_in.bot >> 1);
         v_ff   <= v_ff & link_in.vert;
         r_ff   <= rv_in >> 1;
      end
      if (ctrl.step) begin
         hit_ff <= |(w_ff & b_ff & v_ff & r_ff);
      end
   end

   assign link_out.bot  = b_ff;
   assign link_out.vert = v_ff;
   assign link_out.rgt  = r_ff;
   assign hit           = hit_ff;

endmodule

FILE: hw/rtl/largest_one_bordered_square.sv
// ----------------------------------------------------------------------------
// Largest one-bordered square finder
// Loads a grid row by row and reports the cell count of the largest square
// whose four borders are all ones.
// ----------------------------------------------------------------------------
// Rows are accepted one per cycle while loading. The request that completes a
// grid starts a search in a chain of row cells that tests every square of one
// side length per cycle, from side one up to min(rows, cols), then drains
// before the result is posted, after which loading resumes. A result that is
// still waiting when the next search ends holds back the posting of the new
// result, and with it the loading of the next grid, until it is taken.
`include "assert_macros.svh"

module largest_one_bordered_square #(
   parameter int MAX_DIM = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lobs_pkg::ROW_W-1:0]    req_row_bits,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lobs_pkg::CELLS_W-1:0]  rsp_square_cells,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [lobs_pkg::DIM_W-1:0]    csr_data
);
   import lobs_pkg::*;

   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

   state_type          state_ff, state_in;
   logic [DIM_W-1:0]   rows_loaded_ff, rows_loaded_in;
   logic [DIM_W-1:0]   s_ff, s_in;
   logic [DIM_W-1:0]   best_ff, best_in;
   logic               pend_ff, pend_in;
   logic [DIM_W-1:0]   pend_s_ff, pend_s_in;
   logic [DIM_W-1:0]   grid_rows_ff, grid_cols_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CELLS_W-1:0] rsp_cells_ff, rsp_cells_in;

   logic [DIM_W-1:0]   rows_eff, cols_eff, smax, idx;
   logic [2*DIM_W-1:0] square;
   logic [ROW_W-1:0]   col_mask, row_masked;
   logic               accept, last, start, step, hit_any;
   logic [MAX_DIM-1:0] hit_vec;
   link_type           links [MAX_DIM];

   assign rows_eff = (grid_rows_ff == '0) ? DIM_W'(1) :
                     (grid_rows_ff > DIM_MAX) ? DIM_MAX : grid_rows_ff;
   assign cols_eff = (grid_cols_ff == '0) ? DIM_W'(1) :
                     (grid_cols_ff > DIM_MAX) ? DIM_MAX : grid_cols_ff;
   assign smax     = (rows_eff < cols_eff) ? rows_eff : cols_eff;
   assign idx      = (rows_loaded_ff >= DIM_MAX) ? DIM_MAX - DIM_W'(1) : rows_loaded_ff;

   always_comb begin
      for (int c = 0; c < ROW_W; c++) begin
         col_mask[c] = DIM_W'(c) < cols_eff;
      end
   end

   assign row_masked = req_row_bits & col_mask;
   assign req_stall  = state_ff != ST_LOAD;
   assign accept     = req_valid && !req_stall;
   assign last       = (idx + DIM_W'(1)) >= rows_eff;
   assign start      = accept && last;
   assign step       = state_ff == ST_SEARCH;
   assign hit_any    = |hit_vec;
   assign square     = (2*DIM_W)'(best_ff) * (2*DIM_W)'(best_ff);

   for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
      localparam logic [DIM_W-1:0] CELL_IDX = DIM_W'(i);
      cell_ctrl_type ctrl;
      link_type      link_in;

      assign ctrl.clear = start && (CELL_IDX >= rows_eff);
      assign ctrl.load  = accept && (idx == CELL_IDX);
      assign ctrl.step  = step;

      if (i == MAX_DIM - 1) begin : g_end
         assign link_in = '0;
      end else begin : g_mid
         assign link_in = links[i+1];
      end

      lobs_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .row_bits (row_masked),
         .link_in  (link_in),
         .link_out (links[i]),
         .hit      (hit_vec[i])
      );
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= DIM_W'(64);
         grid_cols_ff <= DIM_W'(64);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GRID_ROWS: grid_rows_ff <= csr_data;
            CSR_GRID_COLS: grid_cols_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         rows_loaded_ff <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rows_loaded_ff <= rows_loaded_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      s_ff         <= s_in;
      best_ff      <= best_in;
      pend_s_ff    <= pend_s_in;
      rsp_cells_ff <= rsp_cells_in;
   end

   always_comb begin
      state_in       = state_ff;
      rows_loaded_in = rows_loaded_ff;
      s_in           = s_ff;
      best_in        = best_ff;
      pend_in        = 1'b0;
      pend_s_in      = s_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_cells_in   = rsp_cells_ff;
      if (pend_ff && hit_any) begin
         best_in = pend_s_ff;
      end
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               rows_loaded_in = last ? '0 : idx + DIM_W'(1);
               if (last) begin
                  state_in = ST_SEARCH;
                  s_in     = DIM_W'(1);
                  best_in  = '0;
               end
            end
         end
         ST_SEARCH: begin
            pend_in = 1'b1;
            s_in    = s_ff + DIM_W'(1);
            if (s_ff == smax) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_cells_in = square[CELLS_W-1:0];
               state_in     = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_square_cells = rsp_cells_ff;

   `ASSERT_IMPLIES(a_step_range, clock, reset, state_ff == ST_SEARCH, (s_ff != '0) && (s_ff <= smax))
   `ASSERT_IMPLIES(a_best_bound, clock, reset, state_ff == ST_DONE, best_ff <= smax)
   `ASSERT_IMPLIES(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)
   `ASSERT_HOLDS(a_load_bound, clock, reset, rows_loaded_ff <= DIM_MAX)

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Bordered square finder testbench
// Loads grids row by row under random idling on both sides and checks each
// reported square size against a behavioral model of the search, across
// several row and column settings including their extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import lobs_pkg::*;

   localparam int DIM = 64;
   localparam int WATCH_LIMIT = 200000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ROW_W-1:0]    req_row_bits = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CELLS_W-1:0]  rsp_square_cells;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = CSR_GRID_ROWS;
   logic [DIM_W-1:0]    csr_data = '0;

   logic [ROW_W-1:0]    grid_rows_seen [DIM];
   int                  rows_stored = 0;
   logic [DIM_W-1:0]    rows_reg = 7'd64;
   logic [DIM_W-1:0]    cols_reg = 7'd64;
   logic [CELLS_W-1:0]  expected_cells [$];
   int                  mismatches = 0;
   int                  squares_seen = 0;
   int                  rows_sent = 0;
   int                  quiet_cycles = 0;
   bit                  stall_free = 1'b0;

   largest_one_bordered_square i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_row_bits(req_row_bits),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_square_cells(rsp_square_cells),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic int clamp_dim(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > DIM) return DIM;
      return int'(v);
   endfunction

   function automatic logic [ROW_W-1:0] ones_below(int n);
      if (n >= 64) return '1;
      return (64'd1 << n) - 64'd1;
   endfunction

   function automatic bit has_border(int r, int c, int s);
      logic [ROW_W-1:0] span;
      logic [ROW_W-1:0] sides;
      span = ones_below(s) << c;
      sides = (64'd1 << c) | (64'd1 << (c + s - 1));
      if ((grid_rows_seen[r] & span) != span) return 1'b0;
      if ((grid_rows_seen[r + s - 1] & span) != span) return 1'b0;
      for (int i = r + 1; i < r + s - 1; i++)
         if ((grid_rows_seen[i] & sides) != sides) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [CELLS_W-1:0] largest_square(int rows, int cols);
      for (int s = (rows < cols) ? rows : cols; s >= 1; s--)
         for (int r = 0; r + s <= rows; r++)
            for (int c = 0; c + s <= cols; c++)
               if (has_border(r, c, s)) return CELLS_W'(s * s);
      return '0;
   endfunction

   // Mirrors the load of one row and queues a result when the grid completes.
   task automatic store_row(logic [ROW_W-1:0] bits);
      int rows;
      int cols;
      int slot;
      rows = clamp_dim(rows_reg);
      cols = clamp_dim(cols_reg);
      slot = (rows_stored >= DIM) ? DIM - 1 : rows_stored;
      grid_rows_seen[slot] = bits & ones_below(cols);
      rows_stored = slot + 1;
      if (rows_stored >= rows) begin
         expected_cells.push_back(largest_square(rows, cols));
         rows_stored = 0;
      end
   endtask

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if (stall_free) n = 0;
      if (n > 0) req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_row(logic [ROW_W-1:0] bits);
      idle_gap();
      req_valid <= 1'b1;
      req_row_bits <= bits;
      do @(posedge clock); while (req_stall);
      store_row(bits);
      rows_sent++;
   endtask

   task automatic write_csr(logic idx, logic [DIM_W-1:0] value);
      req_valid <= 1'b0;
      wait (expected_cells.size() == 0);
      repeat (140) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_GRID_ROWS) rows_reg = value;
      else cols_reg = value;
   endtask

   task automatic set_shape(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
      write_csr(CSR_GRID_ROWS, rows);
      write_csr(CSR_GRID_COLS, cols);
   endtask

   function automatic logic [ROW_W-1:0] random_row(int density);
      logic [ROW_W-1:0] w;
      for (int b = 0; b < ROW_W; b++) w[b] = ($urandom_range(0, 99) < density);
      return w;
   endfunction

   task automatic send_grid(int density);
      int rows;
      rows = clamp_dim(rows_reg);
      for (int i = 0; i < rows; i++) send_row(random_row(density));
   endtask

   task automatic test_full_grids();
      set_shape(7'd64, 7'd64);
      for (int i = 0; i < 64; i++) send_row('1);
      for (int i = 0; i < 64; i++) send_row('0);
   endtask

   task automatic test_single_cell();
      set_shape(7'd1, 7'd1);
      send_row(64'd1);
      send_row(64'hFFFF_FFFF_FFFF_FFFE);
      set_shape(7'd0, 7'd127);
      send_row(64'h8000_0000_0000_0000);
      send_row(64'h5555_5555_5555_5555);
   endtask

   task automatic test_frames();
      set_shape(7'd5, 7'd6);
      send_row(64'hFFFF_FFFF_FFFF_FFDF);
      send_row(64'b100001);
      send_row(64'b101101);
      send_row(64'b100001);
      send_row(64'b011110);
      set_shape(7'd100, 7'd3);
      for (int i = 0; i < 64; i++) send_row((i % 2) ? 64'b101 : 64'b111);
   endtask

   task automatic test_rows_lowered();
      set_shape(7'd10, 7'd8);
      for (int i = 0; i < 6; i++) send_row(64'hFF);
      set_shape(7'd4, 7'd8);
      send_row(64'hFF);
   endtask

   task automatic test_random_grids();
      int dims;
      while (rows_sent < 600) begin
         dims = $urandom_range(0, 9);
         if (dims == 0) set_shape(7'd64, 7'($urandom_range(1, 64)));
         else set_shape(7'($urandom_range(1, 12)), 7'($urandom_range(1, 64)));
         stall_free = ($urandom_range(0, 4) == 0);
         for (int k = 0; k < 3; k++) send_grid($urandom_range(50, 98));
      end
      stall_free = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         squares_seen++;
         if (expected_cells.size() == 0)
            report_mismatch($sformatf("unexpected square_cells %0d", rsp_square_cells));
         else if (rsp_square_cells != expected_cells[0])
            report_mismatch($sformatf("square_cells %0d, expected %0d",
               rsp_square_cells, expected_cells.pop_front()));
         else
            void'(expected_cells.pop_front());
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (stall_free) rsp_stall <= 1'b0;
         else if ($urandom_range(0, 49) == 0) rsp_stall <= 1'b1;
         else if ($urandom_range(0, 3) == 0) rsp_stall <= 1'b0;
         else if ($urandom_range(0, 2) == 0) rsp_stall <= ~rsp_stall;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_full_grids();
      test_single_cell();
      test_frames();
      test_rows_lowered();
      test_random_grids();
      req_valid <= 1'b0;
      wait (expected_cells.size() == 0);
      repeat (200) @(posedge clock);
      $display("Sent %0d rows and checked %0d square results over many grid shapes.",
         rows_sent, squares_seen);
      if (mismatches == 0 && expected_cells.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
